[sv/frustum_cull_classifier_macros.svh]
// Assertion macros shared by the frustum culling classifier modules.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef FRUSTUM_CULL_CLASSIFIER_MACROS_SVH
`define FRUSTUM_CULL_CLASSIFIER_MACROS_SVH

// Checks cons in the same cycle as ante.
`define FCC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks cons in the cycle after ante.
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/fcc_pkg.sv]
// Shared constants, request and verdict codes and the item type of the classifier.
// No dependencies; every other file but the macro header refers to it by scoped names.
package fcc_pkg;

	localparam int PLANE_COUNT = 6;

	localparam int REQ_W = 2;
	localparam int PLANE_IDX_W = 3;
	localparam int COORD_W = 32;
	localparam int VERDICT_W = 2;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * COORD_W;
	localparam int DIST_W = PROD_W + 2;

	localparam int CELL_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
	localparam int CMP_W = (CELL_W > PLANE_IDX_W) ? CELL_W : PLANE_IDX_W;

	// Result queue must cover every item that can be in the chain at once.
	localparam int FIFO_DEPTH = 2 ** $clog2(2 * PLANE_COUNT + 2);
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int LEVEL_W = FIFO_AW + 1;

	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POINT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CORNER = 2'd2;

	localparam logic [VERDICT_W-1:0] VERDICT_INSIDE = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd2;

	// One item as it travels from cell to cell, with the running verdict bits.
	typedef struct packed {
		logic vld;
		logic [REQ_W-1:0] req_type;
		logic [PLANE_IDX_W-1:0] plane_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic signed [COORD_W-1:0] plane_offset;
		logic last_corner;
		logic acc_out;
		logic acc_mix;
	} item_t;

endpackage

[sv/fcc_req_if.sv]
// Request channel of the classifier: valid/ready handshake and request payload.
// Depends on fcc_pkg for field widths.
interface fcc_req_if;
	logic valid;
	logic ready;
	logic [fcc_pkg::REQ_W-1:0] req_type;
	logic [fcc_pkg::PLANE_IDX_W-1:0] plane_index;
	logic signed [fcc_pkg::COORD_W-1:0] coord_x;
	logic signed [fcc_pkg::COORD_W-1:0] coord_y;
	logic signed [fcc_pkg::COORD_W-1:0] coord_z;
	logic signed [fcc_pkg::COORD_W-1:0] plane_offset;
	logic last_corner;

	modport source (
		output valid, req_type, plane_index, coord_x, coord_y, coord_z, plane_offset,
			last_corner,
		input ready
	);
	modport sink (
		input valid, req_type, plane_index, coord_x, coord_y, coord_z, plane_offset,
			last_corner,
		output ready
	);
endinterface

[sv/fcc_res_if.sv]
// Result channel of the classifier: valid/ready handshake and verdict payload.
// Depends on fcc_pkg for the verdict width.
interface fcc_res_if;
	logic valid;
	logic ready;
	logic [fcc_pkg::VERDICT_W-1:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

[sv/fcc_plane_cell.sv]
// One cell of the classifier chain: holds one plane and its box flags.
// Depends on fcc_pkg and frustum_cull_classifier_macros.svh.
`include "frustum_cull_classifier_macros.svh"

module fcc_plane_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic [fcc_pkg::CELL_W-1:0] cell_idx,
	input  fcc_pkg::item_t item_in,
	output fcc_pkg::item_t item_out
);

	localparam int CW = fcc_pkg::CMP_W;

	logic signed [fcc_pkg::COORD_W-1:0] nx_q, ny_q, nz_q, d_q;
	logic in_flags_q, out_flags_q;

	fcc_pkg::item_t item_s1, item_s2;
	logic signed [fcc_pkg::PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [fcc_pkg::COORD_W-1:0] d_s1;

	logic load_hit;
	logic signed [fcc_pkg::PROD_W-1:0] px, py, pz;
	logic signed [fcc_pkg::DIST_W-1:0] d_aligned, dist_sum;
	logic outside, is_corner, is_point, in_new, out_new;
	fcc_pkg::item_t item_nxt;

	assign load_hit = item_in.vld && item_in.req_type == fcc_pkg::REQ_LOAD
		&& CW'(item_in.plane_index) == CW'(cell_idx);

	// Products use the plane as it stands before a load in this same beat lands.
	assign px = fcc_pkg::PROD_W'($signed(item_in.coord_x)) * fcc_pkg::PROD_W'(nx_q);
	assign py = fcc_pkg::PROD_W'($signed(item_in.coord_y)) * fcc_pkg::PROD_W'(ny_q);
	assign pz = fcc_pkg::PROD_W'($signed(item_in.coord_z)) * fcc_pkg::PROD_W'(nz_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= '0;
			d_q <= '0;
			item_s1 <= '0;
			px_s1 <= '0;
			py_s1 <= '0;
			pz_s1 <= '0;
			d_s1 <= '0;
		end else begin
			if (load_hit) begin
				nx_q <= item_in.coord_x;
				ny_q <= item_in.coord_y;
				nz_q <= item_in.coord_z;
				d_q <= item_in.plane_offset;
			end
			item_s1 <= item_in;
			px_s1 <= px;
			py_s1 <= py;
			pz_s1 <= pz;
			d_s1 <= d_q;
		end
	end

	// The offset is Q16.16; shift it up to the Q32.32 scale of the products.
	assign d_aligned = {{(fcc_pkg::DIST_W - fcc_pkg::COORD_W - fcc_pkg::FRAC_W){d_s1[31]}},
		d_s1, {fcc_pkg::FRAC_W{1'b0}}};
	assign dist_sum = fcc_pkg::DIST_W'(px_s1) + fcc_pkg::DIST_W'(py_s1)
		+ fcc_pkg::DIST_W'(pz_s1) + d_aligned;
	assign outside = dist_sum[fcc_pkg::DIST_W-1];

	assign is_corner = item_s1.req_type == fcc_pkg::REQ_CORNER;
	assign is_point = item_s1.req_type == fcc_pkg::REQ_POINT;
	assign in_new = in_flags_q | ~outside;
	assign out_new = out_flags_q | outside;

	always_comb begin
		item_nxt = item_s1;
		if (is_point) begin
			item_nxt.acc_out = item_s1.acc_out | outside;
		end else if (is_corner) begin
			item_nxt.acc_out = item_s1.acc_out | ~in_new;
			item_nxt.acc_mix = item_s1.acc_mix | out_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flags_q <= 1'b0;
			out_flags_q <= 1'b0;
			item_s2 <= '0;
		end else begin
			if (item_s1.vld && is_corner) begin
				if (item_s1.last_corner) begin
					in_flags_q <= 1'b0;
					out_flags_q <= 1'b0;
				end else begin
					in_flags_q <= in_new;
					out_flags_q <= out_new;
				end
			end
			item_s2 <= item_nxt;
		end
	end

	assign item_out = item_s2;

	`FCC_ASSERT_NEXT(a_flags_clear_after_box, item_s1.vld && is_corner && item_s1.last_corner, !in_flags_q && !out_flags_q, "box flags not cleared after last corner")
	`FCC_ASSERT_NEXT(a_point_keeps_flags, item_s1.vld && is_point, $stable(in_flags_q) && $stable(out_flags_q), "point test changed box flags")
	`FCC_ASSERT_NEXT(a_load_writes_plane, load_hit, nx_q == $past(item_in.coord_x) && d_q == $past(item_in.plane_offset), "plane load not stored")

endmodule

[sv/fcc_result_fifo.sv]
// Result queue of the classifier: holds verdicts until the result channel takes them.
// Depends on fcc_pkg and fcc_res_if.
module fcc_result_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [fcc_pkg::VERDICT_W-1:0] push_verdict,
	output logic [fcc_pkg::LEVEL_W-1:0] level,
	fcc_res_if.source res
);

	logic [fcc_pkg::VERDICT_W-1:0] mem_q [fcc_pkg::FIFO_DEPTH];
	logic [fcc_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [fcc_pkg::LEVEL_W-1:0] cnt_q;
	logic pop;

	assign pop = res.valid && res.ready;
	assign res.valid = cnt_q != '0;
	assign res.verdict = mem_q[rd_ptr_q];
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + fcc_pkg::LEVEL_W'(push) - fcc_pkg::LEVEL_W'(pop);
		end
	end

endmodule

[sv/frustum_cull_classifier.sv]
// Top level of the six-plane view frustum classifier.
// Depends on fcc_pkg, fcc_req_if, fcc_res_if, fcc_plane_cell and fcc_result_fifo.
//
// Takes one request beat per clock while ready is high: a plane load, a single point test or
// one box corner, all in Q16.16. Each beat walks a row of PLANE_COUNT cells, one plane per
// cell, through a product step and then a sum step in each (three 32x32 products, then a
// 66-bit sum whose sign says outside). Point tests and last corners give one verdict each;
// loads and other corners give none. Up to FIFO_DEPTH (16) requests may be outstanding;
// ready drops only when that many are in the chain or queued because the result side is
// stalled.
`include "frustum_cull_classifier_macros.svh"

module frustum_cull_classifier (
	input  logic clk,
	input  logic arst_n,
	fcc_req_if.sink req,
	fcc_res_if.source rsp
);

	localparam int CW = fcc_pkg::CELL_W;
	localparam int PW = fcc_pkg::LEVEL_W;

	fcc_pkg::item_t chain [fcc_pkg::PLANE_COUNT + 1];
	fcc_pkg::item_t tail;

	logic [PW-1:0] pend_q;
	logic [PW-1:0] level;
	logic accept, has_result, drop, pop;
	logic [fcc_pkg::VERDICT_W-1:0] verdict;

	assign req.ready = pend_q < PW'(fcc_pkg::FIFO_DEPTH);
	assign accept = req.valid && req.ready;

	always_comb begin
		chain[0].vld = accept;
		chain[0].req_type = req.req_type;
		chain[0].plane_index = req.plane_index;
		chain[0].coord_x = req.coord_x;
		chain[0].coord_y = req.coord_y;
		chain[0].coord_z = req.coord_z;
		chain[0].plane_offset = req.plane_offset;
		chain[0].last_corner = req.last_corner;
		chain[0].acc_out = 1'b0;
		chain[0].acc_mix = 1'b0;
	end

	for (genvar g = 0; g < fcc_pkg::PLANE_COUNT; g++) begin : g_cell
		fcc_plane_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (CW'(g)),
			.item_in  (chain[g]),
			.item_out (chain[g+1])
		);
	end

	assign tail = chain[fcc_pkg::PLANE_COUNT];
	assign has_result = tail.vld && (tail.req_type == fcc_pkg::REQ_POINT
		|| (tail.req_type == fcc_pkg::REQ_CORNER && tail.last_corner));
	assign drop = tail.vld && !has_result;
	assign pop = rsp.valid && rsp.ready;

	always_comb begin
		if (tail.acc_out) begin
			verdict = fcc_pkg::VERDICT_OUTSIDE;
		end else if (tail.acc_mix) begin
			verdict = fcc_pkg::VERDICT_INTERSECT;
		end else begin
			verdict = fcc_pkg::VERDICT_INSIDE;
		end
	end

	fcc_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (has_result),
		.push_verdict (verdict),
		.level        (level),
		.res          (rsp)
	);

	// Counts requests accepted and not yet retired, either dropped or delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + PW'(accept) - PW'(drop) - PW'(pop);
		end
	end

	`FCC_ASSERT_SAME(a_pend_bound, 1'b1, pend_q <= PW'(fcc_pkg::FIFO_DEPTH), "outstanding count above queue depth")
	`FCC_ASSERT_SAME(a_level_within_pend, 1'b1, level <= pend_q, "queue holds more than outstanding requests")
	`FCC_ASSERT_SAME(a_no_push_when_full, has_result, level < PW'(fcc_pkg::FIFO_DEPTH), "verdict pushed into full queue")

endmodule

[sim/frustum_cull_classifier_test.sv]
// Self-checking testbench for frustum_cull_classifier: directed rows, then random
// loads, point tests and corner boxes checked against an in-bench plane classifier.
// Depends on fcc_pkg, fcc_req_if, fcc_res_if and the frustum_cull_classifier RTL.
`timescale 1ns / 1ps

module frustum_cull_classifier_test;

	localparam logic [fcc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic signed [fcc_pkg::COORD_W-1:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [fcc_pkg::COORD_W-1:0] Q_TWO = 32'sh0002_0000;
	localparam logic signed [fcc_pkg::COORD_W-1:0] Q_THREE = 32'sh0003_0000;
	localparam logic signed [fcc_pkg::COORD_W-1:0] Q_HALF = 32'sh0000_8000;
	localparam logic signed [fcc_pkg::COORD_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [fcc_pkg::COORD_W-1:0] Q_MAX = 32'sh7fff_ffff;
	localparam int ITEM_TARGET = 700;
	localparam int HOLD_AT = 200;
	localparam int DRAIN_AT = 420;
	localparam int CALM_AT = 600;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 2 * fcc_pkg::PLANE_COUNT + 8;

	typedef struct {
		logic [fcc_pkg::REQ_W-1:0] kind;
		logic [fcc_pkg::PLANE_IDX_W-1:0] index;
		logic signed [fcc_pkg::COORD_W-1:0] x;
		logic signed [fcc_pkg::COORD_W-1:0] y;
		logic signed [fcc_pkg::COORD_W-1:0] z;
		logic signed [fcc_pkg::COORD_W-1:0] off;
		logic last;
		logic typed;
		logic [fcc_pkg::VERDICT_W-1:0] verdict;
	} fcc_row_t;

	typedef struct {
		logic signed [fcc_pkg::COORD_W-1:0] nx;
		logic signed [fcc_pkg::COORD_W-1:0] ny;
		logic signed [fcc_pkg::COORD_W-1:0] nz;
		logic signed [fcc_pkg::COORD_W-1:0] d;
	} plane_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fcc_req_if req_ch();
	fcc_res_if rsp_ch();

	frustum_cull_classifier i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	plane_t plane_bank[fcc_pkg::PLANE_COUNT];
	logic [fcc_pkg::PLANE_COUNT-1:0] seen_in;
	logic [fcc_pkg::PLANE_COUNT-1:0] seen_out;
	logic [fcc_pkg::VERDICT_W-1:0] verdict_q[$];
	fcc_row_t directed_rows[$];
	int mismatch_count = 0;
	int counted = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	bit drain_done = 1'b0;
	bit calm = 1'b0;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	function automatic logic signed [fcc_pkg::DIST_W-1:0] widen(
			input logic signed [fcc_pkg::COORD_W-1:0] v);
		return fcc_pkg::DIST_W'(v);
	endfunction

	// Exact 66-bit signed distance; only its sign matters.
	function automatic logic plane_rejects(input plane_t pl,
			input logic signed [fcc_pkg::COORD_W-1:0] x,
			input logic signed [fcc_pkg::COORD_W-1:0] y,
			input logic signed [fcc_pkg::COORD_W-1:0] z);
		logic signed [fcc_pkg::DIST_W-1:0] distance;
		distance = widen(pl.nx) * widen(x) + widen(pl.ny) * widen(y)
			+ widen(pl.nz) * widen(z) + (widen(pl.d) <<< fcc_pkg::FRAC_W);
		return distance[fcc_pkg::DIST_W-1];
	endfunction

	task automatic classify_beat(input fcc_row_t r);
		logic [fcc_pkg::PLANE_COUNT-1:0] outs;
		logic [fcc_pkg::VERDICT_W-1:0] v;
		for (int p = 0; p < fcc_pkg::PLANE_COUNT; p++) begin
			outs[p] = plane_rejects(plane_bank[p], r.x, r.y, r.z);
		end
		case (r.kind)
			fcc_pkg::REQ_LOAD: begin
				if (r.index < fcc_pkg::PLANE_COUNT) begin
					plane_bank[r.index] = '{r.x, r.y, r.z, r.off};
				end
			end
			fcc_pkg::REQ_POINT: begin
				v = (|outs) ? fcc_pkg::VERDICT_OUTSIDE : fcc_pkg::VERDICT_INSIDE;
				verdict_q.push_back(r.typed ? r.verdict : v);
			end
			fcc_pkg::REQ_CORNER: begin
				seen_in |= ~outs;
				seen_out |= outs;
				if (r.last) begin
					if (!(&seen_in)) begin
						v = fcc_pkg::VERDICT_OUTSIDE;
					end else if (|seen_out) begin
						v = fcc_pkg::VERDICT_INTERSECT;
					end else begin
						v = fcc_pkg::VERDICT_INSIDE;
					end
					seen_in = '0;
					seen_out = '0;
					verdict_q.push_back(r.typed ? r.verdict : v);
				end
			end
			default: ;
		endcase
	endtask

	function automatic fcc_row_t mk_row(input logic [fcc_pkg::REQ_W-1:0] kind,
			input logic [fcc_pkg::PLANE_IDX_W-1:0] index,
			input logic signed [fcc_pkg::COORD_W-1:0] x,
			input logic signed [fcc_pkg::COORD_W-1:0] y,
			input logic signed [fcc_pkg::COORD_W-1:0] z,
			input logic signed [fcc_pkg::COORD_W-1:0] off, input logic last,
			input logic typed, input logic [fcc_pkg::VERDICT_W-1:0] verdict);
		fcc_row_t r;
		r = '{kind, index, x, y, z, off, last, typed, verdict};
		return r;
	endfunction

	function automatic fcc_row_t noise_row();
		fcc_row_t r;
		r.kind = fcc_pkg::REQ_W'($urandom_range(0, 3));
		r.index = fcc_pkg::PLANE_IDX_W'($urandom_range(0, 7));
		r.x = $urandom;
		r.y = $urandom;
		r.z = $urandom;
		r.off = $urandom;
		r.last = 1'($urandom_range(0, 1));
		r.typed = 1'b0;
		r.verdict = fcc_pkg::VERDICT_INSIDE;
		return r;
	endfunction

	// Mostly within two units of the origin, sometimes anywhere.
	function automatic logic signed [fcc_pkg::COORD_W-1:0] near_coord();
		logic signed [fcc_pkg::COORD_W-1:0] c;
		if ($urandom_range(0, 9) < 8) begin
			c = $urandom_range(0, 4 * 65536);
			c = c - Q_TWO;
		end else begin
			c = $urandom;
		end
		return c;
	endfunction

	function automatic logic signed [fcc_pkg::COORD_W-1:0] jitter();
		logic signed [fcc_pkg::COORD_W-1:0] j;
		j = $urandom_range(0, 8192);
		return j - 32'sd4096;
	endfunction

	// A plane of a jittered axis-aligned box, inward normal, so boxes straddle often.
	function automatic fcc_row_t box_plane_row(input int idx);
		fcc_row_t r;
		logic signed [fcc_pkg::COORD_W-1:0] n[3];
		r = noise_row();
		r.kind = fcc_pkg::REQ_LOAD;
		r.index = fcc_pkg::PLANE_IDX_W'(idx);
		for (int a = 0; a < 3; a++) begin
			n[a] = jitter();
		end
		if (idx < fcc_pkg::PLANE_COUNT) begin
			n[(idx / 2) % 3] += (idx % 2) ? -Q_ONE : Q_ONE;
		end
		r.x = n[0];
		r.y = n[1];
		r.z = n[2];
		r.off = $urandom_range(32768, 163840);
		return r;
	endfunction

	task automatic offer_beat(input fcc_row_t r);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.plane_index <= r.index;
		req_ch.coord_x <= r.x;
		req_ch.coord_y <= r.y;
		req_ch.coord_z <= r.z;
		req_ch.plane_offset <= r.off;
		req_ch.last_corner <= r.last;
		do @(posedge clk); while (!req_ch.ready);
		classify_beat(r);
	endtask

	task automatic issue(input fcc_row_t r);
		offer_beat(r);
		if (!(r.kind == REQ_UNUSED
				|| (r.kind == fcc_pkg::REQ_LOAD && r.index >= fcc_pkg::PLANE_COUNT))) begin
			counted++;
		end
		calm = (counted >= CALM_AT);
		if (counted >= HOLD_AT && !hold_done) begin
			hold_done = 1'b1;
			hold_req = 1'b1;
		end
		if (counted >= DRAIN_AT && !drain_done) begin
			// Sender stops until every verdict in flight has been delivered.
			drain_done = 1'b1;
			req_ch.valid <= 1'b0;
			do @(posedge clk); while (verdict_q.size() != 0);
		end else if (!calm && (counted / 50) % 3 != 0 && $urandom_range(0, 6) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic issue_box();
		fcc_row_t r;
		logic signed [fcc_pkg::COORD_W-1:0] cx, cy, cz, hx, hy, hz;
		int n;
		bit garbage;
		n = ($urandom_range(0, 9) < 7) ? 8 : $urandom_range(1, 12);
		garbage = ($urandom_range(0, 9) == 0);
		cx = near_coord();
		cy = near_coord();
		cz = near_coord();
		hx = $urandom_range(0, 65536);
		hy = $urandom_range(0, 65536);
		hz = $urandom_range(0, 65536);
		for (int k = 0; k < n; k++) begin
			// Occasionally break up the box with an unrelated beat.
			if ($urandom_range(0, 19) == 0) begin
				r = noise_row();
				if (r.kind == fcc_pkg::REQ_CORNER) begin
					r.kind = fcc_pkg::REQ_POINT;
				end
				issue(r);
			end
			r = noise_row();
			r.kind = fcc_pkg::REQ_CORNER;
			r.last = (k == n - 1);
			if (!garbage) begin
				r.x = cx + ((k & 1) ? hx : -hx);
				r.y = cy + ((k & 2) ? hy : -hy);
				r.z = cz + ((k & 4) ? hz : -hz);
			end
			issue(r);
		end
	endtask

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[frustum_cull_classifier] ERROR");
		$finish;
	end

	// Result side: random ready bursts, one long hold-off on request, none at the end.
	initial begin
		int run;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				hold_req = 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
			end else if (calm) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
				rsp_ch.ready <= 1'b1;
				repeat (run) @(posedge clk);
				if (!calm && !hold_req && $urandom_range(0, 1) == 0) begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 17)) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("verdict %0d with nothing outstanding", rsp_ch.verdict));
			end else if (rsp_ch.verdict !== verdict_q[0]) begin
				report_mismatch($sformatf("verdict %0d, wanted %0d", rsp_ch.verdict,
					verdict_q.pop_front()));
			end else begin
				void'(verdict_q.pop_front());
			end
		end
	end

	initial begin
		fcc_row_t r;
		req_ch.valid = 1'b0;
		req_ch.req_type = fcc_pkg::REQ_LOAD;
		req_ch.plane_index = '0;
		req_ch.coord_x = '0;
		req_ch.coord_y = '0;
		req_ch.coord_z = '0;
		req_ch.plane_offset = '0;
		req_ch.last_corner = 1'b0;
		for (int p = 0; p < fcc_pkg::PLANE_COUNT; p++) begin
			plane_bank[p] = '{'0, '0, '0, '0};
		end
		seen_in = '0;
		seen_out = '0;

		// Planes are all zero after reset, so every point sits on every plane.
		directed_rows.push_back(mk_row(fcc_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, 1,
			fcc_pkg::VERDICT_INSIDE));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_CORNER, 0, Q_MAX, Q_MIN, Q_MAX, 0, 1, 1,
			fcc_pkg::VERDICT_INSIDE));
		directed_rows.push_back(mk_row(REQ_UNUSED, 7, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 6, Q_ONE, Q_ONE, Q_ONE, Q_MIN,
			0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 7, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			0, 0, 0));
		// Unit cube: |x|, |y|, |z| <= 1.
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 0, Q_ONE, 0, 0, Q_ONE, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 1, -Q_ONE, 0, 0, Q_ONE, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 2, 0, Q_ONE, 0, Q_ONE, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 3, 0, -Q_ONE, 0, Q_ONE, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 4, 0, 0, Q_ONE, Q_ONE, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 5, 0, 0, -Q_ONE, Q_ONE, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_POINT, 0, Q_TWO, 0, 0, 0, 0, 0, 0));
		// A point exactly on three planes counts as in.
		directed_rows.push_back(mk_row(fcc_pkg::REQ_POINT, 0, -Q_ONE, -Q_ONE, -Q_ONE, 0,
			0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_CORNER, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_CORNER, 0, Q_HALF, Q_HALF, Q_HALF, 0,
			1, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_CORNER, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_CORNER, 0, Q_TWO, 0, 0, 0, 1, 0, 0));
		// Each plane sees at least one corner in, so this is intersecting, not outside.
		directed_rows.push_back(mk_row(fcc_pkg::REQ_CORNER, 0, Q_THREE, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_CORNER, 0, 0, Q_THREE, 0, 0, 1, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_CORNER, 0, Q_THREE, Q_THREE, 0, 0,
			1, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 5, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_POINT, 0, Q_MIN, Q_MIN, Q_MIN, 0,
			0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_LOAD, 4, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			0, 0, 0));
		directed_rows.push_back(mk_row(fcc_pkg::REQ_POINT, 0, Q_MAX, Q_MAX, Q_MAX, 0,
			0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			issue(directed_rows[i]);
		end

		while (counted < ITEM_TARGET) begin
			case ($urandom_range(0, 99)) inside
				[0:7]: begin
					if ($urandom_range(0, 3) != 0) begin
						r = box_plane_row($urandom_range(0, 7));
					end else begin
						r = noise_row();
						r.kind = fcc_pkg::REQ_LOAD;
					end
					issue(r);
				end
				[8:10]: begin
					r = noise_row();
					r.kind = REQ_UNUSED;
					issue(r);
				end
				[11:34]: begin
					r = noise_row();
					r.kind = fcc_pkg::REQ_POINT;
					r.x = near_coord();
					r.y = near_coord();
					r.z = near_coord();
					issue(r);
				end
				default: issue_box();
			endcase
		end
		req_ch.valid <= 1'b0;

		while (verdict_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[frustum_cull_classifier] OK");
		end else begin
			$display("[frustum_cull_classifier] ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/fcc_pkg.sv
sv/fcc_req_if.sv
sv/fcc_res_if.sv
sv/fcc_plane_cell.sv
sv/fcc_result_fifo.sv
sv/frustum_cull_classifier.sv
sim/frustum_cull_classifier_test.sv
